// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/svrc_pkg.sv =====
// ----------------------------------------------------------------------------
// svrc_pkg
// Types and constants shared by the stereo volume ramp controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svrc_pkg;

	localparam int unsigned VOLUME_STEPS = 200;
	localparam int unsigned NUM_PAIRS    = 2;
	localparam int unsigned MAX_PAIRS    = 3;
	localparam int unsigned NUM_CH       = 2 * MAX_PAIRS;

	localparam logic [7:0]  LEVEL_CUTOFF = 8'hF0;
	localparam logic [7:0]  LOW_LEVEL    = 8'd8;
	localparam logic [7:0]  STEPS_LEVEL  = 8'(VOLUME_STEPS);

	localparam logic [7:0]  MAX_VOLUME_RST = 8'd200;
	localparam logic [15:0] STEP_TICKS_RST = 16'd1;

	typedef enum logic [1:0] {
		KIND_SET    = 2'd0,
		KIND_MUTE   = 2'd1,
		KIND_UNMUTE = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_BALANCE      = 3'd0,
		REG_MAX_VOLUME   = 3'd1,
		REG_MIN_VOLUME   = 3'd2,
		REG_OFFSET_PAIR0 = 3'd3,
		REG_OFFSET_PAIR1 = 3'd4,
		REG_OFFSET_PAIR2 = 3'd5,
		REG_STEP_TICKS   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] requested_level;
	} cmd_t;

	typedef struct packed {
		logic [7:0] applied_level;
		logic [7:0] att_ch0;
		logic [7:0] att_ch1;
		logic [7:0] att_ch2;
		logic [7:0] att_ch3;
		logic [7:0] att_ch4;
		logic [7:0] att_ch5;
		logic       max_reached;
		logic       ramp_done;
	} res_t;

	typedef struct packed {
		logic [7:0]                  balance;
		logic [7:0]                  max_volume;
		logic [7:0]                  min_volume;
		logic [MAX_PAIRS-1:0][7:0]   offset_pair;
		logic [15:0]                 step_ticks;
	} cfg_regs_t;

	typedef struct packed {
		logic [NUM_CH-1:0][7:0] att;
		logic                   capped;
	} att_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stereo_volume_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// stereo_volume_ramp_controller
// Volume request clamping, mute handling and a tick-paced level ramp that
// emits per-channel attenuation words on every ramp step.
// ----------------------------------------------------------------------------
// Usage:
// Requests (set volume, mute, unmute, tick) arrive on cmd with cmd_valid and
// cmd_ready. Only a tick that moves the applied level produces a result,
// which leaves on res with res_valid and res_ready; all other requests are
// absorbed silently. A request is captured in an input register and handled
// from there; a result that it produces is registered in the output register
// before it is offered. One request can be accepted every cycle unless a
// waiting step holds the input register.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data,
// which is always ready; write them only while no request is in flight.
// Reset clears the level, target, stored volume, mute flag and tick count,
// and returns the registers to their defaults (maximum 200, one tick a step).
// If the receiver stalls, the result is held in the output register; the
// input register keeps taking requests that produce no result, and a step
// waits there until the output register is free, which drops cmd_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_volume_ramp_controller (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire svrc_pkg::cmd_t      cmd,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output svrc_pkg::res_t           res,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);

	svrc_pkg::cfg_regs_t cfg_q;

	logic           cmd_valid_s1;
	svrc_pkg::cmd_t cmd_s1;

	logic [7:0]  cur_q;
	logic [7:0]  tgt_q;
	logic [7:0]  stored_q;
	logic        muted_q;
	logic [15:0] tick_q;

	logic           res_valid_q;
	svrc_pkg::res_t res_q;

	logic [7:0]  clamped;
	logic [15:0] tick_next;
	logic        at_target;
	logic        step;
	logic        s1_go;
	logic [7:0]  next_level;

	svrc_pkg::att_out_t att;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.balance     <= '0;
			cfg_q.max_volume  <= svrc_pkg::MAX_VOLUME_RST;
			cfg_q.min_volume  <= '0;
			cfg_q.offset_pair <= '0;
			cfg_q.step_ticks  <= svrc_pkg::STEP_TICKS_RST;
		end else if (cfg_valid) begin
			case (svrc_pkg::reg_idx_t'(cfg_index))
				svrc_pkg::REG_BALANCE:      cfg_q.balance        <= cfg_data[7:0];
				svrc_pkg::REG_MAX_VOLUME:   cfg_q.max_volume     <= cfg_data[7:0];
				svrc_pkg::REG_MIN_VOLUME:   cfg_q.min_volume     <= cfg_data[7:0];
				svrc_pkg::REG_OFFSET_PAIR0: cfg_q.offset_pair[0] <= cfg_data[7:0];
				svrc_pkg::REG_OFFSET_PAIR1: cfg_q.offset_pair[1] <= cfg_data[7:0];
				svrc_pkg::REG_OFFSET_PAIR2: cfg_q.offset_pair[2] <= cfg_data[7:0];
				svrc_pkg::REG_STEP_TICKS:   cfg_q.step_ticks     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request clamp: out-of-range values become zero, then the step limit and the
	// configured maximum apply, then the minimum.
	always_comb begin
		logic [7:0] v;
		v = cmd_s1.requested_level;
		if (v >= svrc_pkg::LEVEL_CUTOFF) begin
			v = 8'd0;
		end else if (v > svrc_pkg::STEPS_LEVEL) begin
			v = svrc_pkg::STEPS_LEVEL;
		end else if (v > cfg_q.max_volume) begin
			v = cfg_q.max_volume;
		end
		if (v <= cfg_q.min_volume) begin
			v = (v < svrc_pkg::LOW_LEVEL) ? cfg_q.min_volume : 8'd0;
		end
		clamped = v;
	end

	assign at_target  = (cur_q == tgt_q);
	assign tick_next  = tick_q + 16'd1;
	assign step       = (cmd_s1.kind == svrc_pkg::KIND_TICK) && !at_target
		&& (tick_next >= cfg_q.step_ticks);
	assign next_level = (cur_q < tgt_q) ? cur_q + 8'd1 : cur_q - 8'd1;

	assign s1_go     = cmd_valid_s1 && (!step || !res_valid_q || res_ready);
	assign cmd_ready = !cmd_valid_s1 || s1_go;

	svrc_att u_att (
		.level  (next_level),
		.cfg    (cfg_q),
		.result (att)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			tgt_q    <= '0;
			stored_q <= '0;
			muted_q  <= 1'b0;
			tick_q   <= '0;
		end else if (s1_go) begin
			case (cmd_s1.kind)
				svrc_pkg::KIND_SET: begin
					stored_q <= clamped;
					if (!muted_q) begin
						tgt_q <= clamped;
					end
				end
				svrc_pkg::KIND_MUTE: begin
					if (!muted_q) begin
						muted_q <= 1'b1;
						tgt_q   <= '0;
					end
				end
				svrc_pkg::KIND_UNMUTE: begin
					if (muted_q) begin
						muted_q <= 1'b0;
						tgt_q   <= stored_q;
					end
				end
				svrc_pkg::KIND_TICK: begin
					if (at_target || step) begin
						tick_q <= '0;
					end else begin
						tick_q <= tick_next;
					end
					if (step) begin
						cur_q <= next_level;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && step) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && step) begin
			res_q.applied_level <= next_level;
			res_q.att_ch0       <= att.att[0];
			res_q.att_ch1       <= att.att[1];
			res_q.att_ch2       <= att.att[2];
			res_q.att_ch3       <= att.att[3];
			res_q.att_ch4       <= att.att[4];
			res_q.att_ch5       <= att.att[5];
			res_q.max_reached   <= att.capped;
			res_q.ramp_done     <= (next_level == tgt_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/svrc_att.sv =====
// ----------------------------------------------------------------------------
// svrc_att
// Per-channel attenuation words for a given applied level: balance cut,
// pair offset, floor at zero and cap at the maximum volume.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svrc_att (
	input  wire logic [7:0]         level,
	input  wire svrc_pkg::cfg_regs_t cfg,
	output svrc_pkg::att_out_t      result
);

	logic signed [10:0] lvl_ext;
	logic signed [10:0] bal_ext;
	logic signed [10:0] cut_left;
	logic signed [10:0] cut_right;

	assign lvl_ext   = signed'({3'b000, level});
	assign bal_ext   = signed'({{3{cfg.balance[7]}}, cfg.balance});
	assign cut_left  = cfg.balance[7] ? 11'sd0 : bal_ext;
	assign cut_right = cfg.balance[7] ? bal_ext : 11'sd0;

	always_comb begin
		logic signed [10:0] off_ext;
		logic signed [10:0] raw [2];
		result = '0;
		for (int c = 0; c < svrc_pkg::MAX_PAIRS; c++) begin
			off_ext = signed'({{3{cfg.offset_pair[c][7]}}, cfg.offset_pair[c]});
			if (level == 8'd0) begin
				raw[0] = 11'sd0;
				raw[1] = 11'sd0;
			end else begin
				raw[0] = lvl_ext - cut_left + off_ext;
				raw[1] = lvl_ext + cut_right + off_ext;
			end
			if (c < svrc_pkg::NUM_PAIRS) begin
				for (int s = 0; s < 2; s++) begin
					if (raw[s] < 11'sd0) begin
						raw[s] = 11'sd0;
					end
					// Anything at or above the maximum is held there and flagged.
					if (raw[s][9:0] >= {2'b00, cfg.max_volume}) begin
						result.att[2*c+s] = cfg.max_volume;
						result.capped     = 1'b1;
					end else begin
						result.att[2*c+s] = raw[s][7:0];
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/svrc_checker.sv =====
// ----------------------------------------------------------------------------
// svrc_checker
// Port-level checks for the stereo volume ramp controller, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module svrc_port_checks (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_ready,
	input wire logic           res_valid,
	input wire logic           res_ready,
	input wire svrc_pkg::res_t res
);

	// A held result must not change under back-pressure.
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(res))

	// With the output register empty nothing can block the input side.
	`ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !res_valid, cmd_ready)

	// Successive results move the level by exactly one step.
	`ASSERT_IMPL(a_single_step, clk, arst_n, res_valid && $past(res_valid && res_ready),
		res.applied_level == $past(res.applied_level) + 8'd1
		|| res.applied_level == $past(res.applied_level) - 8'd1)

	// At level zero no balance or offset is applied, so every channel is silent.
	`ASSERT_IMPL(a_zero_level, clk, arst_n, res_valid && res.applied_level == 8'd0,
		res.att_ch0 == 8'd0 && res.att_ch1 == 8'd0
		&& res.att_ch2 == 8'd0 && res.att_ch3 == 8'd0)

endmodule

bind stereo_volume_ramp_controller svrc_port_checks u_svrc_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_ready (cmd_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

`default_nettype wire
